// ----- sv/lobst_pkg.sv -----
// Shared types, register codes and constants for the laser obstacle steering block.
`timescale 1ns / 1ps
package lobst_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 23;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GOAL_X    = 3'd0,
    REG_GOAL_Y    = 3'd1,
    REG_HIT_RANGE = 3'd2,
    REG_MAX_ANGLE = 3'd3,
    REG_DENS_THR  = 3'd4,
    REG_DAMPING   = 3'd5,
    REG_DECAY     = 3'd6,
    REG_TURN_SPD  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic        [15:0] hit_range;
    logic        [14:0] max_angle;
    logic        [22:0] density_threshold;
    logic        [15:0] damping_gain;
    logic        [15:0] decay_factor;
    logic        [13:0] turn_speed;
  } cfg_t;

  // Register reset values.
  localparam logic signed [15:0] GOAL_X_RST    = 16'sd5120;
  localparam logic signed [15:0] GOAL_Y_RST    = 16'sd0;
  localparam logic        [15:0] HIT_RANGE_RST = 16'd384;
  localparam logic        [14:0] MAX_ANGLE_RST = 15'd14700;
  localparam logic        [22:0] DENS_THR_RST  = 23'd77169;
  localparam logic        [15:0] DAMPING_RST   = 16'd5243;
  localparam logic        [15:0] DECAY_RST     = 16'd64881;
  localparam logic        [13:0] TURN_SPD_RST  = 14'd4096;

  localparam logic        [23:0] DENS_MAX    = 24'hFFFFFF;
  localparam logic signed [19:0] HIST_MAX    = 20'sd81920;
  localparam logic signed [19:0] HIST_BOUND  = 20'sd90111;
  localparam logic signed [16:0] NEAR_GOAL   = 17'sd192;
  localparam logic        [12:0] CRUISE      = 13'd5120;
  localparam logic signed [15:0] AVOID_TURN  = 16'sd4096;
  localparam logic signed [14:0] TAN_EPS_Q20 = 15'sd10486;
  localparam logic signed [34:0] ONE_Q29     = 35'sd536870912;
  localparam logic signed [15:0] TURN_MAX    = 16'sd32767;
  localparam logic signed [15:0] TURN_MIN    = 16'sh8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_PROD,
    ST_CLAMP,
    ST_GAIN,
    ST_SCALE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic hit_en;
    logic capture;
    logic diff;
    logic prod;
    logic clamp;
    logic gain;
    logic scale;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } sts_t;

endpackage

// ----- sv/lobst_cfg.sv -----
// Configuration register file for the laser obstacle steering block.
`timescale 1ns / 1ps
module lobst_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [lobst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lobst_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output lobst_pkg::cfg_t                      cfg_o
);
  import lobst_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_GOAL_X:    cfg_nxt.goal_x            = $signed(cfg_wdata[15:0]);
        REG_GOAL_Y:    cfg_nxt.goal_y            = $signed(cfg_wdata[15:0]);
        REG_HIT_RANGE: cfg_nxt.hit_range         = cfg_wdata[15:0];
        REG_MAX_ANGLE: cfg_nxt.max_angle         = cfg_wdata[14:0];
        REG_DENS_THR:  cfg_nxt.density_threshold = cfg_wdata[22:0];
        REG_DAMPING:   cfg_nxt.damping_gain      = cfg_wdata[15:0];
        REG_DECAY:     cfg_nxt.decay_factor      = cfg_wdata[15:0];
        REG_TURN_SPD:  cfg_nxt.turn_speed        = cfg_wdata[13:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.goal_x            <= GOAL_X_RST;
      cfg_r.goal_y            <= GOAL_Y_RST;
      cfg_r.hit_range         <= HIT_RANGE_RST;
      cfg_r.max_angle         <= MAX_ANGLE_RST;
      cfg_r.density_threshold <= DENS_THR_RST;
      cfg_r.damping_gain      <= DAMPING_RST;
      cfg_r.decay_factor      <= DECAY_RST;
      cfg_r.turn_speed        <= TURN_SPD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ----- sv/lobst_ctrl.sv -----
// Sequencer that steps a decide beat through the steering datapath.
`timescale 1ns / 1ps
module lobst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_stall,
  input  lobst_pkg::sts_t   sts_i,
  output lobst_pkg::cmd_t   cmd_o
);
  import lobst_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept && in_kind) state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_PROD;
      ST_PROD:  state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_GAIN;
      ST_GAIN:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_DONE;
      ST_DONE:  if (!sts_i.out_blocked) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    in_stall      = (state_r != ST_IDLE);
    cmd_o.hit_en  = accept && !in_kind;
    cmd_o.capture = accept && in_kind;
    cmd_o.diff    = (state_r == ST_DIFF);
    cmd_o.prod    = (state_r == ST_PROD);
    cmd_o.clamp   = (state_r == ST_CLAMP);
    cmd_o.gain    = (state_r == ST_GAIN);
    cmd_o.scale   = (state_r == ST_SCALE);
    cmd_o.finish  = (state_r == ST_DONE) && !sts_i.out_blocked;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_capture_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.capture |=> state_r == ST_DIFF)
    else $error("decide beat did not start the sequence");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.finish |-> !sts_i.out_blocked)
    else $error("result written over an untaken one");

  a_no_hit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !cmd_o.hit_en && !cmd_o.capture)
    else $error("beat taken while a decide is in progress");
`endif

endmodule

// ----- sv/lobst_dp.sv -----
// Datapath: density accumulation, goal test, history decay and turn scaling.
`timescale 1ns / 1ps
module lobst_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lobst_pkg::cfg_t          cfg_i,
  input  lobst_pkg::cmd_t          cmd_i,
  output lobst_pkg::sts_t          sts_o,
  input  logic [15:0]              in_hit_distance,
  input  logic signed [15:0]       in_hit_angle,
  input  logic signed [15:0]       in_pos_x,
  input  logic signed [15:0]       in_pos_y,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [12:0]              out_velocity,
  output logic signed [15:0]       out_turn_rate,
  output logic                     out_goal_reached
);
  import lobst_pkg::*;

  // Obstacle densities and turn history.
  logic        [23:0] left_r, left_nxt;
  logic        [23:0] right_r, right_nxt;
  logic signed [19:0] hist_r, hist_nxt;

  // Decide pipeline registers.
  logic signed [15:0] px_r, py_r;
  logic signed [16:0] dx_r, dy_r;
  logic               dense_r, lgt_r;
  logic               near_r;
  logic signed [31:0] tdx_r;
  logic        [19:0] decm_r;
  logic               hneg_r;
  logic signed [19:0] hc_r;
  logic               tl_r, tr_r;
  logic        [32:0] gh_r;
  logic signed [49:0] prod_r;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic        [12:0] vel_r;
  logic signed [15:0] turn_r, turn_nxt;
  logic               goal_r;

  // Hit accumulation.
  logic signed [16:0] ang17, ma17;
  logic               dist_ok, in_left, in_right;
  logic        [14:0] add_left, add_right;
  logic        [24:0] sum_left, sum_right;

  always_comb begin
    ang17     = {in_hit_angle[15], in_hit_angle};
    ma17      = {2'b00, cfg_i.max_angle};
    dist_ok   = in_hit_distance < cfg_i.hit_range;
    in_left   = dist_ok && (ang17 > 17'sd0) && (ang17 < ma17);
    in_right  = dist_ok && (ang17 <= 17'sd0) && (ang17 > -ma17);
    add_left  = 15'(ma17 - ang17);
    add_right = 15'(ma17 + ang17);
    sum_left  = {1'b0, left_r} + {10'd0, add_left};
    sum_right = {1'b0, right_r} + {10'd0, add_right};
  end

  // Stage products and compares.
  logic        [19:0] hmag;
  logic        [35:0] dec_prod;
  logic signed [31:0] tdx_nxt;
  logic signed [19:0] hdec, hc_nxt;
  logic signed [37:0] dy20, tdx38;
  logic        [16:0] hsel;
  logic signed [34:0] fac;
  logic signed [49:0] prod_nxt;

  always_comb begin
    hmag     = hist_r[19] ? 20'(-hist_r) : 20'(hist_r);
    dec_prod = 36'(hmag) * 36'(cfg_i.decay_factor);
    tdx_nxt  = 32'(TAN_EPS_Q20) * 32'(dx_r);

    hdec = hneg_r ? -$signed(decm_r) : $signed(decm_r);
    if (hdec > HIST_MAX) begin
      hc_nxt = HIST_MAX;
    end else if (hdec < -HIST_MAX) begin
      hc_nxt = -HIST_MAX;
    end else begin
      hc_nxt = hdec;
    end
    // Goal angle against +-0.01 rad: dy * 2^20 compared with tan(0.01) * dx.
    dy20  = {dy_r[16], dy_r, 20'd0};
    tdx38 = {{6{tdx_r[31]}}, tdx_r};

    if (tl_r) begin
      hsel = (hc_r > 20'sd0) ? 17'(hc_r) : 17'd0;
    end else begin
      hsel = (hc_r < 20'sd0) ? 17'(-hc_r) : 17'd0;
    end

    fac      = ONE_Q29 - $signed({2'b00, gh_r});
    prod_nxt = 50'($signed({1'b0, cfg_i.turn_speed})) * 50'(fac);
  end

  // Final rounding, saturation and history update.
  logic        [49:0] pmag;
  logic        [50:0] rnd;
  logic        [21:0] rmag;
  logic               fneg;
  logic signed [15:0] sat_turn;
  logic signed [19:0] half_ts;

  always_comb begin
    pmag    = prod_r[49] ? 50'(-prod_r) : 50'(prod_r);
    rnd     = {1'b0, pmag} + (51'd1 << 28);
    rmag    = rnd[50:29];
    fneg    = prod_r[49] ^ tr_r;
    half_ts = $signed({7'd0, cfg_i.turn_speed[13:1]});
    if (!fneg) begin
      sat_turn = (rmag > 22'd32767) ? TURN_MAX : $signed(rmag[15:0]);
    end else begin
      sat_turn = (rmag > 22'd32768) ? TURN_MIN : -$signed(rmag[15:0]);
    end

    turn_nxt = '0;
    hist_nxt = hist_r;
    if (near_r) begin
      turn_nxt = '0;
    end else if (dense_r) begin
      turn_nxt = lgt_r ? AVOID_TURN : -AVOID_TURN;
      hist_nxt = '0;
    end else if (tl_r) begin
      turn_nxt = sat_turn;
      hist_nxt = hc_r + half_ts;
    end else if (tr_r) begin
      turn_nxt = sat_turn;
      hist_nxt = hc_r - half_ts;
    end else begin
      hist_nxt = hc_r;
    end
  end

  always_comb begin
    left_nxt  = left_r;
    right_nxt = right_r;
    if (cmd_i.finish) begin
      left_nxt  = '0;
      right_nxt = '0;
    end else if (cmd_i.hit_en) begin
      if (in_left) begin
        left_nxt = sum_left[24] ? DENS_MAX : sum_left[23:0];
      end else if (in_right) begin
        right_nxt = sum_right[24] ? DENS_MAX : sum_right[23:0];
      end
    end
    if (cmd_i.finish) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      right_r     <= '0;
      hist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      if (cmd_i.finish) begin
        hist_r <= hist_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      px_r <= in_pos_x;
      py_r <= in_pos_y;
    end
    if (cmd_i.diff) begin
      dx_r    <= {cfg_i.goal_x[15], cfg_i.goal_x} - {px_r[15], px_r};
      dy_r    <= {cfg_i.goal_y[15], cfg_i.goal_y} - {py_r[15], py_r};
      dense_r <= ({1'b0, left_r} + {1'b0, right_r}) > {2'b00, cfg_i.density_threshold};
      lgt_r   <= left_r > right_r;
    end
    if (cmd_i.prod) begin
      near_r <= (dx_r > -NEAR_GOAL) && (dx_r < NEAR_GOAL) &&
                (dy_r > -NEAR_GOAL) && (dy_r < NEAR_GOAL);
      tdx_r  <= tdx_nxt;
      decm_r <= dec_prod[35:16];
      hneg_r <= hist_r[19];
    end
    if (cmd_i.clamp) begin
      hc_r <= hc_nxt;
      tl_r <= (dy_r < 17'sd0) && ((dx_r <= 17'sd0) || (dy20 < -tdx38));
      tr_r <= ((dy_r > 17'sd0) && ((dx_r <= 17'sd0) || (dy20 > tdx38))) ||
              ((dy_r == 17'sd0) && (dx_r < 17'sd0));
    end
    if (cmd_i.gain) begin
      gh_r <= 33'(hsel) * 33'(cfg_i.damping_gain);
    end
    if (cmd_i.scale) begin
      prod_r <= prod_nxt;
    end
    if (cmd_i.finish) begin
      vel_r  <= near_r ? 13'd0 : CRUISE;
      turn_r <= turn_nxt;
      goal_r <= near_r;
    end
  end

  assign sts_o.out_blocked = out_valid_r && out_stall;
  assign out_valid         = out_valid_r;
  assign out_velocity      = vel_r;
  assign out_turn_rate     = turn_r;
  assign out_goal_reached  = goal_r;

`ifndef SYNTH
  a_dens_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.finish |=> left_r == 24'd0 && right_r == 24'd0)
    else $error("densities not cleared after a decide");

  a_hist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hist_r <= HIST_BOUND && hist_r >= -HIST_BOUND)
    else $error("turn history outside its clamped range");

  a_goal_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && goal_r |-> vel_r == 13'd0 && turn_r == 16'sd0)
    else $error("goal beat carries motion");
`endif

endmodule

// ----- sv/laser_obstacle_steering_step.sv -----
// A laser hit beat is folded into the densities when it is accepted; no result follows.
// Hit beats are taken one per cycle while no decide is in progress; a decide beat holds the input
// while the six-step sequencer runs and while the previous result still waits at the output
// register, so a new beat is not taken until the decide before it has written its result.
// The result of a decide is registered as the sequencer leaves DONE, after DIFF, PROD, CLAMP, GAIN and SCALE.
// Reset (synchronous, rst_n low) restores the register defaults and clears densities and history.
`timescale 1ns / 1ps
module laser_obstacle_steering_step (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_kind,
  input  logic [15:0]                          in_hit_distance,
  input  logic signed [15:0]                   in_hit_angle,
  input  logic signed [15:0]                   in_pos_x,
  input  logic signed [15:0]                   in_pos_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [12:0]                          out_velocity,
  output logic signed [15:0]                   out_turn_rate,
  output logic                                 out_goal_reached,
  input  logic                                 cfg_wr_en,
  input  logic [lobst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lobst_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import lobst_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  lobst_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  lobst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  lobst_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_hit_distance  (in_hit_distance),
    .in_hit_angle     (in_hit_angle),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_velocity     (out_velocity),
    .out_turn_rate    (out_turn_rate),
    .out_goal_reached (out_goal_reached)
  );

endmodule
